FILE: rtl/core/bsof_pkg.sv
package bsof_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int BLOCK_BYTES = 16;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int NUM_BANKS   = BLOCK_BYTES / 2;
  localparam int WORD_BITS   = 64;
  localparam int STATE_BITS  = 8 * BLOCK_BYTES;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCAN  = 1'b1;

  localparam logic [15:0] DOMAIN_MASK_RESET = 16'd8191;
  localparam logic [63:0] START_RESET       = '1;

  typedef enum logic [1:0] {
    REG_DOMAIN_MASK = 2'd0,
    REG_STRIDE_MODE = 2'd1,
    REG_START_LOW   = 2'd2,
    REG_START_HIGH  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STRIDE_1   = 2'd0,
    STRIDE_2   = 2'd1,
    STRIDE_4   = 2'd2,
    STRIDE_OFF = 2'd3
  } stride_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [7:0]  next_byte;
    logic        first_block;
    logic [15:0] entry_index;
    logic [63:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] candidates_low;
    logic [63:0] candidates_high;
  } out_item_t;

  typedef struct packed {
    logic                  en;
    logic [INDEX_BITS-1:0] addr;
    logic [WORD_BITS-1:0]  data;
  } tbl_write_t;

endpackage

FILE: rtl/core/bsof_table_bank.sv
// One copy of the bucket table, serving two sample positions per cycle.
module bsof_table_bank (
  input  logic                                clk,
  input  bsof_pkg::tbl_write_t                wr,
  input  logic                                rd_en,
  input  logic [bsof_pkg::INDEX_BITS-1:0]     rd_addr_a,
  input  logic [bsof_pkg::INDEX_BITS-1:0]     rd_addr_b,
  output logic [bsof_pkg::WORD_BITS-1:0]      rd_data_a,
  output logic [bsof_pkg::WORD_BITS-1:0]      rd_data_b
);
  import bsof_pkg::*;

  logic [WORD_BITS-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: rtl/core/bucketed_shift_or_literal_filter_top.sv
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   in_data   (bsof_pkg::in_item_t)
// out      out  out_valid / out_ready out_data  (bsof_pkg::out_item_t)
// cfg      in   cfg_write             cfg_index, cfg_data (no wait, no read-back)
//
// One item per cycle while in_ready is high. A scan result, once its request is taken, passes the
// table read (registered), then the shift-or merge into the result register.
// Table writes complete at the edge they are taken and produce no result.
// Reset clears the carry and valid flags and loads the config defaults; the table is not cleared.
// A stalled output holds the merge stage; input stalls only when both stages are full.
module bucketed_shift_or_literal_filter_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsof_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsof_pkg::out_item_t  out_data,
  input  logic                 cfg_write,
  input  bsof_pkg::cfg_reg_t   cfg_index,
  input  logic [63:0]          cfg_data
);
  import bsof_pkg::*;

  logic [15:0] domain_mask;
  stride_t     stride_mode;
  logic [63:0] start_low;
  logic [63:0] start_high;

  logic [63:0] carry_low;

  logic        s1_valid;
  logic        s1_first;
  stride_t     s1_stride;
  logic        s1_adv;
  logic        s1_load;
  logic        accept;

  logic [8*BLOCK_BYTES+7:0]  blk;
  logic [INDEX_BITS-1:0]     rd_addr [BLOCK_BYTES];
  logic [WORD_BITS-1:0]      rd_word [BLOCK_BYTES];
  tbl_write_t                tbl_wr;

  logic [STATE_BITS+WORD_BITS-1:0] acc;
  logic [STATE_BITS-1:0]           carry_in;
  out_item_t                       result;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      domain_mask <= DOMAIN_MASK_RESET;
      stride_mode <= STRIDE_1;
      start_low   <= START_RESET;
      start_high  <= START_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DOMAIN_MASK: domain_mask <= cfg_data[15:0];
        REG_STRIDE_MODE: stride_mode <= stride_t'(cfg_data[1:0]);
        REG_START_LOW:   start_low   <= cfg_data;
        REG_START_HIGH:  start_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign s1_load  = accept && (in_data.mode == MODE_SCAN) && (stride_mode != STRIDE_OFF);

  // index generation: bytes k and k+1, byte 16 is next_byte
  assign blk = {in_data.next_byte, in_data.block_high, in_data.block_low};

  always_comb begin
    logic [15:0] raw;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      raw        = blk[8*k +: 16] & domain_mask;
      rd_addr[k] = raw[INDEX_BITS-1:0];
    end
  end

  always_comb begin
    tbl_wr.en   = accept && (in_data.mode == MODE_WRITE);
    tbl_wr.addr = in_data.entry_index[INDEX_BITS-1:0];
    tbl_wr.data = in_data.entry_value;
  end

  // each bank holds a full copy so all sixteen positions read in the same cycle
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    bsof_table_bank u_bank (
      .clk       (clk),
      .wr        (tbl_wr),
      .rd_en     (s1_load),
      .rd_addr_a (rd_addr[2*b]),
      .rd_addr_b (rd_addr[2*b+1]),
      .rd_data_a (rd_word[2*b]),
      .rd_data_b (rd_word[2*b+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_first  <= in_data.first_block;
      s1_stride <= stride_mode;
    end
  end

  // shift-or merge
  always_comb begin
    logic sampled;
    acc = '0;
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      case (s1_stride)
        STRIDE_1: sampled = 1'b1;
        STRIDE_2: sampled = (k % 2) == 0;
        STRIDE_4: sampled = (k % 4) == 0;
        default:  sampled = 1'b0;
      endcase
      if (sampled) begin
        acc = acc | ({{STATE_BITS{1'b0}}, rd_word[k]} << (8 * k));
      end
    end
  end

  // carry_high is always zero between scans, only a start load sets it
  assign carry_in = s1_first ? {start_high, start_low} : {64'd0, carry_low};

  always_comb begin
    logic [STATE_BITS-1:0] st;
    st = ~(carry_in | acc[STATE_BITS-1:0]);
    result.candidates_low  = st[63:0];
    result.candidates_high = st[127:64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_low <= '0;
    end else if (s1_valid && s1_adv) begin
      carry_low <= acc[STATE_BITS +: WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_data <= result;
    end
  end

  // checks
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("merge stage dropped a held scan");

  a_carry_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && s1_adv) |=> $stable(carry_low))
    else $error("carry changed without a scan leaving the merge stage");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared with no scan in the merge stage");

  a_no_scan_entry: assert property (@(posedge clk) disable iff (rst)
    accept && !s1_load |=> !s1_valid)
    else $error("write or disabled-stride request entered the merge stage");

endmodule
